// File: design/i2cee_pkg.sv
// Shared types and constants of the I2C EEPROM byte master.
// Item structs, configuration struct, phase and byte-stage encodings.
// No dependencies; imported by every module of the block.
package i2cee_pkg;

  localparam int unsigned AddrW = 3;

  typedef logic [1:0] opcode_t;
  localparam opcode_t OP_TICK  = 2'd0;
  localparam opcode_t OP_WRITE = 2'd1;
  localparam opcode_t OP_READ  = 2'd2;

  localparam logic REG_DEVICE_SELECT = 1'b0;
  localparam logic REG_ACK_TIMEOUT   = 1'b1;

  localparam logic [6:0] DEVICE_SELECT_RST = 7'd80;
  localparam logic [7:0] ACK_TIMEOUT_RST   = 8'd200;

  typedef struct packed {
    opcode_t    opcode;
    logic [7:0] mem_addr;
    logic [7:0] write_data;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_release;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       no_ack;
  } out_item_t;

  typedef struct packed {
    logic [6:0] device_select;
    logic [7:0] ack_timeout;
  } cfg_t;

  typedef struct packed {
    logic idle;
  } fsm_stat_t;

  typedef enum logic [16:0] {
    PH_IDLE  = 17'h00001,
    PH_ST1   = 17'h00002,
    PH_ST2   = 17'h00004,
    PH_ST3   = 17'h00008,
    PH_ST4   = 17'h00010,
    PH_BSET  = 17'h00020,
    PH_BHI   = 17'h00040,
    PH_BLO   = 17'h00080,
    PH_AREL  = 17'h00100,
    PH_APOLL = 17'h00200,
    PH_AEND  = 17'h00400,
    PH_RHI   = 17'h00800,
    PH_RSMP  = 17'h01000,
    PH_RLO   = 17'h02000,
    PH_SP1   = 17'h04000,
    PH_SP2   = 17'h08000,
    PH_SP3   = 17'h10000
  } phase_e;

  typedef enum logic [2:0] {
    STG_DEV_WR = 3'd0,
    STG_ADDR   = 3'd1,
    STG_DATA   = 3'd2,
    STG_DEV_RD = 3'd3,
    STG_RECV   = 3'd4
  } stage_e;

endpackage

// File: design/i2cee_regs.sv
// APB-style configuration registers: device select and acknowledge timeout.
// Depends on i2cee_pkg for the register indexes and reset values.
module i2cee_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [i2cee_pkg::AddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output i2cee_pkg::cfg_t           cfg_o
);
  import i2cee_pkg::*;

  logic [6:0] dev_sel_q;
  logic [7:0] ack_to_q;
  logic       wr_en;
  logic       reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_sel_q <= DEVICE_SELECT_RST;
      ack_to_q  <= ACK_TIMEOUT_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_DEVICE_SELECT: dev_sel_q <= pwdata[6:0];
        REG_ACK_TIMEOUT:   ack_to_q  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DEVICE_SELECT: prdata = {25'd0, dev_sel_q};
      REG_ACK_TIMEOUT:   prdata = {24'd0, ack_to_q};
      default:           prdata = 32'd0;
    endcase
  end

  assign cfg_o.device_select = dev_sel_q;
  assign cfg_o.ack_timeout   = ack_to_q;

endmodule

// File: design/i2cee_fsm.sv
// Bus phase sequencer: one phase per input item, with the transaction state.
// Depends on i2cee_pkg for item types, phase and byte-stage encodings.
module i2cee_fsm (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  i2cee_pkg::in_item_t   item_i,
  input  i2cee_pkg::cfg_t       cfg_i,
  output i2cee_pkg::out_item_t  res_o,
  output i2cee_pkg::fsm_stat_t  stat_o
);
  import i2cee_pkg::*;

  phase_e     phase_q, phase_d;
  stage_e     stage_q, stage_d;
  logic [3:0] bit_cnt_q, bit_cnt_d;
  logic [3:0] bit_cnt_inc;
  logic [7:0] shifter_q, shifter_d;
  logic [7:0] polls_q, polls_d;
  logic       is_read_q, is_read_d;
  logic [7:0] addr_q, addr_d;
  logic [7:0] data_q, data_d;
  logic [7:0] rcvd_q, rcvd_d;
  logic       ack_fail_q, ack_fail_d;
  logic [7:0] wr_byte;
  logic       scl, sda, busy, done;

  assign wr_byte     = {cfg_i.device_select, 1'b0};
  assign bit_cnt_inc = bit_cnt_q + 4'd1;

  always_comb begin
    phase_d    = phase_q;
    stage_d    = stage_q;
    bit_cnt_d  = bit_cnt_q;
    shifter_d  = shifter_q;
    polls_d    = polls_q;
    is_read_d  = is_read_q;
    addr_d     = addr_q;
    data_d     = data_q;
    rcvd_d     = rcvd_q;
    ack_fail_d = ack_fail_q;
    scl        = 1'b1;
    sda        = 1'b1;
    busy       = 1'b1;
    done       = 1'b0;
    case (phase_q)
      PH_IDLE: begin
        if (item_i.opcode == OP_WRITE || item_i.opcode == OP_READ) begin
          is_read_d  = (item_i.opcode == OP_READ);
          addr_d     = item_i.mem_addr;
          data_d     = item_i.write_data;
          ack_fail_d = 1'b0;
          stage_d    = STG_DEV_WR;
          phase_d    = PH_ST2;
        end else begin
          busy = 1'b0;
        end
      end
      PH_ST1: begin
        scl     = 1'b0;
        phase_d = PH_ST2;
      end
      PH_ST2: phase_d = PH_ST3;
      PH_ST3: begin
        sda     = 1'b0;
        phase_d = PH_ST4;
      end
      PH_ST4: begin
        scl       = 1'b0;
        sda       = 1'b0;
        bit_cnt_d = '0;
        phase_d   = PH_BSET;
        if (stage_q == STG_DEV_RD) begin
          shifter_d = wr_byte + 8'd1;
        end else begin
          stage_d   = STG_DEV_WR;
          shifter_d = wr_byte;
        end
      end
      PH_BSET: begin
        scl     = 1'b0;
        sda     = shifter_q[7];
        phase_d = PH_BHI;
      end
      PH_BHI: begin
        sda     = shifter_q[7];
        phase_d = PH_BLO;
      end
      PH_BLO: begin
        scl       = 1'b0;
        sda       = shifter_q[7];
        shifter_d = {shifter_q[6:0], 1'b0};
        bit_cnt_d = bit_cnt_inc;
        phase_d   = (bit_cnt_inc >= 4'd8) ? PH_AREL : PH_BSET;
      end
      PH_AREL: begin
        scl     = 1'b0;
        polls_d = '0;
        phase_d = PH_APOLL;
      end
      PH_APOLL: begin
        if (!item_i.sda_in) begin
          phase_d = PH_AEND;
        end else if (polls_q >= cfg_i.ack_timeout) begin
          ack_fail_d = 1'b1;
          phase_d    = PH_AEND;
        end else begin
          polls_d = polls_q + 8'd1;
        end
      end
      PH_AEND: begin
        scl = 1'b0;
        case (stage_q)
          STG_DEV_WR: begin
            stage_d   = STG_ADDR;
            shifter_d = addr_q;
            bit_cnt_d = '0;
            phase_d   = PH_BSET;
          end
          STG_ADDR: begin
            if (is_read_q) begin
              stage_d = STG_DEV_RD;
              phase_d = PH_ST1;
            end else begin
              stage_d   = STG_DATA;
              shifter_d = data_q;
              bit_cnt_d = '0;
              phase_d   = PH_BSET;
            end
          end
          STG_DEV_RD: begin
            stage_d   = STG_RECV;
            shifter_d = '0;
            bit_cnt_d = '0;
            phase_d   = PH_RHI;
          end
          default: phase_d = PH_SP1;
        endcase
      end
      PH_RHI: phase_d = PH_RSMP;
      PH_RSMP: begin
        shifter_d = {shifter_q[6:0], item_i.sda_in};
        phase_d   = PH_RLO;
      end
      PH_RLO: begin
        scl       = 1'b0;
        bit_cnt_d = bit_cnt_inc;
        if (bit_cnt_inc >= 4'd8) begin
          rcvd_d  = shifter_q;
          phase_d = PH_SP1;
        end else begin
          phase_d = PH_RHI;
        end
      end
      PH_SP1: begin
        scl     = 1'b0;
        sda     = 1'b0;
        phase_d = PH_SP2;
      end
      PH_SP2: begin
        sda     = 1'b0;
        phase_d = PH_SP3;
      end
      default: begin
        // stop completes: SDA rises with SCL high
        done    = 1'b1;
        phase_d = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      stage_q    <= STG_DEV_WR;
      bit_cnt_q  <= '0;
      shifter_q  <= '0;
      polls_q    <= '0;
      is_read_q  <= 1'b0;
      addr_q     <= '0;
      data_q     <= '0;
      rcvd_q     <= '0;
      ack_fail_q <= 1'b0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      stage_q    <= stage_d;
      bit_cnt_q  <= bit_cnt_d;
      shifter_q  <= shifter_d;
      polls_q    <= polls_d;
      is_read_q  <= is_read_d;
      addr_q     <= addr_d;
      data_q     <= data_d;
      rcvd_q     <= rcvd_d;
      ack_fail_q <= ack_fail_d;
    end
  end

  assign res_o.scl_out     = scl;
  assign res_o.sda_release = sda;
  assign res_o.busy_res    = busy;
  assign res_o.done_res    = done;
  assign res_o.read_byte   = rcvd_d;
  assign res_o.no_ack      = ack_fail_d;

  assign stat_o.idle = (phase_q == PH_IDLE);

endmodule

// File: design/i2c_eeprom_byte_master_core.sv
// Top level of the I2C EEPROM byte master: input register, sequencer, result register.
// Depends on i2cee_pkg, i2cee_regs and i2cee_fsm.
//
//   port group   direction  handshake                   payload
//   in           in         in_valid_i / in_ready_o     in_i  (i2cee_pkg::in_item_t)
//   out          out        out_valid_o / out_ready_i   out_o (i2cee_pkg::out_item_t)
//   cfg          in         psel, penable, pready       paddr, pwdata, prdata
//
// Each item's result becomes valid once the item has waited in the input register
// and the phase sequencer has computed its result into the result register.
// One item per cycle unless stalled; the sequencer advances one bus phase per item.
// Reset puts the bus idle with both lines released and the registers at defaults.
// A stalled result holds the sequencer; the input register still takes one item.
module i2c_eeprom_byte_master_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  i2cee_pkg::in_item_t         in_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output i2cee_pkg::out_item_t        out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [i2cee_pkg::AddrW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import i2cee_pkg::*;

  in_item_t  in_q;
  logic      in_vld_q;
  out_item_t res_q;
  out_item_t res_d;
  logic      res_vld_q;
  logic      step;
  cfg_t      cfg;
  fsm_stat_t stat;

  // advance when an item waits and the result slot is free or draining
  assign step       = in_vld_q && (!res_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (step) begin
        res_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_i;
    end
    if (step) begin
      res_q <= res_d;
    end
  end

  i2cee_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  i2cee_fsm u_fsm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_q),
    .cfg_i  (cfg),
    .res_o  (res_d),
    .stat_o (stat)
  );

  assign out_valid_o = res_vld_q;
  assign out_o       = res_q;

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (in_vld_q && out_valid_o && !out_ready_i))
    else $error("input stalled while a stage was free");

  a_cmd_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && stat.idle && (in_q.opcode == OP_WRITE || in_q.opcode == OP_READ))
      |=> (!stat.idle && out_o.busy_res))
    else $error("command did not start a transaction");

  a_done_returns_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.done_res) |-> (stat.idle && out_o.scl_out && out_o.sda_release))
    else $error("stop completed but sequencer not idle");

  a_idle_result_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && stat.idle && in_q.opcode != OP_WRITE && in_q.opcode != OP_READ)
      |=> (!out_o.busy_res && stat.idle))
    else $error("idle tick reported busy");

endmodule
